FILE: rtl/core/clfr_pkg.sv
// Shared types, codes and helper functions for the serial frame receiver.
// No dependencies; every other file of the block refers to this package.
`timescale 1ns / 1ps

package clfr_pkg;

    // Depth of the queue between the classifying front and the deframer
    localparam int QUEUE_DEPTH = 4;

    // Configuration register indexes
    localparam logic [1:0] CFG_MIN_LENGTH = 2'd0;
    localparam logic [1:0] CFG_MAX_LENGTH = 2'd1;
    localparam logic [1:0] CFG_FRAME_TO   = 2'd2;
    localparam logic [1:0] CFG_BYTE_TO    = 2'd3;

    // Configuration reset values
    localparam logic [7:0]  RST_MIN_LENGTH = 8'd3;
    localparam logic [7:0]  RST_MAX_LENGTH = 8'd255;
    localparam logic [15:0] RST_FRAME_TO   = 16'd3000;
    localparam logic [15:0] RST_BYTE_TO    = 16'd500;

    // Item kinds
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // Frame status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NAK      = 3'd1;
    localparam logic [2:0] ST_CSUM_BAD = 3'd2;
    localparam logic [2:0] ST_BYTE_TO  = 3'd3;
    localparam logic [2:0] ST_FRAME_TO = 3'd4;

    // Reply codes
    localparam logic [1:0] REPLY_NONE     = 2'd0;
    localparam logic [1:0] REPLY_ACK      = 2'd1;
    localparam logic [1:0] REPLY_CSUM_NAK = 2'd2;

    // Flag bits in the header
    localparam logic [7:0] ACK_FLAG    = 8'h80;
    localparam logic [7:0] NOTIFY_FLAG = 8'h40;

    // NAK reason bytes
    localparam logic [7:0] NAK_NONE     = 8'h00;
    localparam logic [7:0] NAK_BUSY     = 8'h01;
    localparam logic [7:0] NAK_LENGTH   = 8'h02;
    localparam logic [7:0] NAK_SEQUENCE = 8'h03;
    localparam logic [7:0] NAK_COMM     = 8'h04;
    localparam logic [7:0] NAK_CHECKSUM = 8'h10;

    // Notify error bytes
    localparam logic [7:0] NTF_CABLE        = 8'h00;
    localparam logic [7:0] NTF_CAMERA_COMM  = 8'h01;
    localparam logic [7:0] NTF_PAN_TILT     = 8'h03;
    localparam logic [7:0] NTF_VIDEO        = 8'h04;
    localparam logic [7:0] NTF_UNCONNECTED  = 8'h10;
    localparam logic [7:0] NTF_UNDEF_CMD    = 8'h11;
    localparam logic [7:0] NTF_UNDEF_PARAM  = 8'h12;
    localparam logic [7:0] NTF_CMD_STATUS   = 8'h13;
    localparam logic [7:0] NTF_PARAM_STATUS = 8'h14;
    localparam logic [7:0] NTF_TIMEOUT      = 8'h16;
    localparam logic [7:0] NTF_WHITE_BAL    = 8'h18;
    localparam logic [7:0] NTF_ADJUST       = 8'h20;

    // Dense response error codes
    localparam logic [4:0] ERR_NONE           = 5'd0;
    localparam logic [4:0] ERR_NAK_BUSY       = 5'd1;
    localparam logic [4:0] ERR_NAK_LENGTH     = 5'd2;
    localparam logic [4:0] ERR_NAK_SEQUENCE   = 5'd3;
    localparam logic [4:0] ERR_NAK_COMM       = 5'd4;
    localparam logic [4:0] ERR_NAK_CHECKSUM   = 5'd5;
    localparam logic [4:0] ERR_NAK_UNKNOWN    = 5'd6;
    localparam logic [4:0] ERR_CABLE          = 5'd7;
    localparam logic [4:0] ERR_CAMERA_COMM    = 5'd8;
    localparam logic [4:0] ERR_PAN_TILT_BASE  = 5'd9;
    localparam logic [4:0] ERR_VIDEO_BASE     = 5'd13;
    localparam logic [4:0] ERR_UNCONNECTED    = 5'd17;
    localparam logic [4:0] ERR_UNDEF_CMD      = 5'd18;
    localparam logic [4:0] ERR_UNDEF_PARAM    = 5'd19;
    localparam logic [4:0] ERR_CMD_STATUS     = 5'd20;
    localparam logic [4:0] ERR_PARAM_STATUS   = 5'd21;
    localparam logic [4:0] ERR_TIMEOUT        = 5'd22;
    localparam logic [4:0] ERR_WHITE_BAL      = 5'd23;
    localparam logic [4:0] ERR_ADJUST         = 5'd24;
    localparam logic [4:0] ERR_NOTIFY_UNKNOWN = 5'd25;
    localparam logic [4:0] SUB_UNKNOWN        = 5'd3;

    // Input request
    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
    } clfr_in_t;

    // Result request
    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] byte_index;
        logic       frame_end;
        logic [2:0] status;
        logic       is_ack;
        logic [1:0] reply;
        logic [4:0] response_error;
    } clfr_out_t;

    // Classified item held in the queue
    typedef struct packed {
        logic       is_tick;
        logic       in_bounds;
        logic [7:0] rx_byte;
    } clfr_item_t;

    // Configuration set
    typedef struct packed {
        logic [7:0]  min_length;
        logic [7:0]  max_length;
        logic [15:0] frame_timeout_ms;
        logic [15:0] byte_timeout_ms;
    } clfr_cfg_t;

    // Device sub-code: reasons 0 to 2 map directly, the rest is unknown
    function automatic logic [4:0] sub_code(input logic [7:0] v, input logic [4:0] base);
        logic [4:0] code;
        if (v <= 8'd2)
        begin
            code = base + {3'b000, v[1:0]};
        end
        else
        begin
            code = base + SUB_UNKNOWN;
        end
        return code;
    endfunction

    // Translate header bytes 1 to 4 into the dense response error code
    function automatic logic [4:0] translate(input logic [7:0] b1, input logic [7:0] b2,
                                             input logic [7:0] b3, input logic [7:0] b4);
        logic [4:0] code;
        if ((b1 & ACK_FLAG) != 8'h00)
        begin
            case (b2)
                NAK_NONE:     code = ERR_NONE;
                NAK_BUSY:     code = ERR_NAK_BUSY;
                NAK_LENGTH:   code = ERR_NAK_LENGTH;
                NAK_SEQUENCE: code = ERR_NAK_SEQUENCE;
                NAK_COMM:     code = ERR_NAK_COMM;
                NAK_CHECKSUM: code = ERR_NAK_CHECKSUM;
                default:      code = ERR_NAK_UNKNOWN;
            endcase
        end
        else if ((b2 & NOTIFY_FLAG) == 8'h00)
        begin
            code = ERR_NONE;
        end
        else
        begin
            case (b3)
                NTF_CABLE:        code = ERR_CABLE;
                NTF_CAMERA_COMM:  code = ERR_CAMERA_COMM;
                NTF_PAN_TILT:     code = sub_code(b4, ERR_PAN_TILT_BASE);
                NTF_VIDEO:        code = sub_code(b4, ERR_VIDEO_BASE);
                NTF_UNCONNECTED:  code = ERR_UNCONNECTED;
                NTF_UNDEF_CMD:    code = ERR_UNDEF_CMD;
                NTF_UNDEF_PARAM:  code = ERR_UNDEF_PARAM;
                NTF_CMD_STATUS:   code = ERR_CMD_STATUS;
                NTF_PARAM_STATUS: code = ERR_PARAM_STATUS;
                NTF_TIMEOUT:      code = ERR_TIMEOUT;
                NTF_WHITE_BAL:    code = ERR_WHITE_BAL;
                NTF_ADJUST:       code = ERR_ADJUST;
                default:          code = ERR_NOTIFY_UNKNOWN;
            endcase
        end
        return code;
    endfunction

endpackage

FILE: rtl/core/clfr_front.sv
// Front of the frame receiver: classifies incoming requests against the
// length bounds and queues them for the deframer. Depends on clfr_pkg.
`timescale 1ns / 1ps

module clfr_front #(
    parameter int DEPTH = clfr_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [7:0]            min_length,
    input  logic [7:0]            max_length,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  clfr_pkg::clfr_in_t    item,
    output logic                  q_valid,
    output clfr_pkg::clfr_item_t  q_item,
    input  logic                  q_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    clfr_pkg::clfr_item_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    clfr_pkg::clfr_item_t classified;
    logic push;

    // Classify: kind of request and whether a byte is a legal length
    always_comb
    begin
        classified.is_tick   = (item.action == clfr_pkg::ACT_TICK);
        classified.in_bounds = (item.rx_byte >= min_length) && (item.rx_byte <= max_length);
        classified.rx_byte   = item.rx_byte;
    end

    // Stall while the queue is full
    assign item_stall = (count_reg == CNT_W'(DEPTH));
    assign push       = item_valid && !item_stall;
    assign q_valid    = (count_reg != '0);
    assign q_item     = entry_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the classified request
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= classified;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill count above depth");

    a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && !push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue pop without push did not drain one entry");

    a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !q_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue push without pop did not add one entry");

endmodule

FILE: rtl/core/clfr_back.sv
// Back of the frame receiver: deframing state, timers, checksum and the
// output register. Depends on clfr_pkg for types, codes and translate().
`timescale 1ns / 1ps

module clfr_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [15:0]           frame_timeout_ms,
    input  logic [15:0]           byte_timeout_ms,
    input  logic                  q_valid,
    input  clfr_pkg::clfr_item_t  q_item,
    output logic                  q_pop,
    output logic                  result_valid,
    input  logic                  result_stall,
    output clfr_pkg::clfr_out_t   result
);

    logic        collecting_reg, collecting_next;
    logic [7:0]  bytes_left_reg, bytes_left_next;
    logic [7:0]  position_reg, position_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  header_reg [4];
    logic [7:0]  header_next [4];
    logic [15:0] hunt_reg, hunt_next;
    logic [15:0] gap_reg, gap_next;
    logic        out_valid_reg, out_valid_next;
    clfr_pkg::clfr_out_t out_reg, out_next;

    logic        advance;
    logic        emit;
    logic        finish;
    logic        good;
    logic [15:0] hunt_inc;
    logic [15:0] gap_inc;
    logic [7:0]  pos_inc;
    logic [7:0]  pos_m1;
    logic [7:0]  left_dec;
    clfr_pkg::clfr_out_t res;

    assign advance      = !out_valid_reg || !result_stall;
    assign q_pop        = q_valid && advance;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    assign hunt_inc = (hunt_reg == 16'hFFFF) ? hunt_reg : hunt_reg + 16'd1;
    assign gap_inc  = (gap_reg == 16'hFFFF) ? gap_reg : gap_reg + 16'd1;
    assign pos_inc  = position_reg + 8'd1;
    assign pos_m1   = pos_inc - 8'd1;
    assign left_dec = bytes_left_reg - 8'd1;

    // Deframe one queued request
    always_comb
    begin
        collecting_next = collecting_reg;
        bytes_left_next = bytes_left_reg;
        position_next   = position_reg;
        sum_next        = sum_reg;
        hunt_next       = hunt_reg;
        gap_next        = gap_reg;
        for (int i = 0; i < 4; i++)
        begin
            header_next[i] = header_reg[i];
        end
        emit   = 1'b0;
        finish = 1'b0;
        good   = 1'b1;
        res    = '0;

        if (q_pop)
        begin
            if (q_item.is_tick)
            begin
                hunt_next = hunt_inc;
                if (!collecting_reg)
                begin
                    // hunt deadline on a tick
                    if (hunt_inc >= frame_timeout_ms)
                    begin
                        emit            = 1'b1;
                        res.frame_end   = 1'b1;
                        res.status      = clfr_pkg::ST_FRAME_TO;
                        hunt_next       = '0;
                        gap_next        = '0;
                        bytes_left_next = '0;
                    end
                end
                else
                begin
                    gap_next = gap_inc;
                    // inter-byte deadline
                    if (gap_inc >= byte_timeout_ms)
                    begin
                        emit            = 1'b1;
                        res.frame_end   = 1'b1;
                        res.status      = clfr_pkg::ST_BYTE_TO;
                        collecting_next = 1'b0;
                        bytes_left_next = '0;
                        gap_next        = '0;
                        hunt_next       = '0;
                    end
                end
            end
            else if (!collecting_reg)
            begin
                if (!q_item.in_bounds)
                begin
                    // drop the byte, but honor the hunt deadline
                    if (hunt_reg >= frame_timeout_ms)
                    begin
                        emit            = 1'b1;
                        res.frame_end   = 1'b1;
                        res.status      = clfr_pkg::ST_FRAME_TO;
                        hunt_next       = '0;
                        gap_next        = '0;
                        bytes_left_next = '0;
                    end
                end
                else
                begin
                    // length byte opens a frame
                    for (int i = 0; i < 4; i++)
                    begin
                        header_next[i] = '0;
                    end
                    position_next  = '0;
                    sum_next       = q_item.rx_byte;
                    gap_next       = '0;
                    emit           = 1'b1;
                    res.data_byte  = q_item.rx_byte;
                    res.byte_index = '0;
                    if (q_item.rx_byte == 8'd0)
                    begin
                        // zero length frame completes at once
                        finish = 1'b1;
                    end
                    else
                    begin
                        collecting_next = 1'b1;
                        bytes_left_next = q_item.rx_byte;
                    end
                end
            end
            else
            begin
                // frame body byte
                gap_next        = '0;
                position_next   = pos_inc;
                bytes_left_next = left_dec;
                if (pos_inc inside {[8'd1:8'd4]})
                begin
                    header_next[pos_m1[1:0]] = q_item.rx_byte;
                end
                emit           = 1'b1;
                res.data_byte  = q_item.rx_byte;
                res.byte_index = pos_inc;
                if (left_dec == 8'd0)
                begin
                    finish = 1'b1;
                    good   = ((8'd0 - sum_reg) == q_item.rx_byte);
                end
                else
                begin
                    sum_next = sum_reg + q_item.rx_byte;
                end
            end

            // Close the frame: checksum verdict, then ACK/NAK classification
            if (finish)
            begin
                res.frame_end   = 1'b1;
                collecting_next = 1'b0;
                bytes_left_next = '0;
                gap_next        = '0;
                if (!good)
                begin
                    res.status = clfr_pkg::ST_CSUM_BAD;
                    res.reply  = clfr_pkg::REPLY_CSUM_NAK;
                end
                else
                begin
                    hunt_next          = '0;
                    res.response_error = clfr_pkg::translate(header_next[0], header_next[1],
                                                             header_next[2], header_next[3]);
                    if ((header_next[0] & clfr_pkg::ACK_FLAG) != 8'h00)
                    begin
                        res.is_ack = 1'b1;
                        res.status = (header_next[1] == 8'h00) ? clfr_pkg::ST_OK
                                                               : clfr_pkg::ST_NAK;
                        res.reply  = clfr_pkg::REPLY_NONE;
                    end
                    else
                    begin
                        res.status = clfr_pkg::ST_OK;
                        res.reply  = clfr_pkg::REPLY_ACK;
                    end
                end
            end
        end
    end

    // Load or hold the output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (advance)
        begin
            out_valid_next = q_pop && emit;
            out_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            collecting_reg <= 1'b0;
            bytes_left_reg <= '0;
            position_reg   <= '0;
            sum_reg        <= '0;
            hunt_reg       <= '0;
            gap_reg        <= '0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                header_reg[i] <= '0;
            end
        end
        else
        begin
            collecting_reg <= collecting_next;
            bytes_left_reg <= bytes_left_next;
            position_reg   <= position_next;
            sum_reg        <= sum_next;
            hunt_reg       <= hunt_next;
            gap_reg        <= gap_next;
            out_valid_reg  <= out_valid_next;
            for (int i = 0; i < 4; i++)
            begin
                header_reg[i] <= header_next[i];
            end
        end
    end

    // Payload register
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    a_left_tracks_mode: assert property (@(posedge clk) disable iff (!rst_n)
        collecting_reg == (bytes_left_reg != 8'd0))
        else $error("bytes left out of step with collecting mode");

    a_mid_frame_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.frame_end) |->
        (out_reg.status == clfr_pkg::ST_OK && out_reg.reply == clfr_pkg::REPLY_NONE &&
         out_reg.response_error == clfr_pkg::ERR_NONE && !out_reg.is_ack))
        else $error("mid-frame result carries frame status");

    a_timeout_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.status == clfr_pkg::ST_BYTE_TO ||
                           out_reg.status == clfr_pkg::ST_FRAME_TO)) |->
        (out_reg.data_byte == 8'd0 && out_reg.byte_index == 8'd0 && out_reg.frame_end))
        else $error("timeout result carries frame data");

    a_length_opens: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && !collecting_reg && !q_item.is_tick && q_item.in_bounds &&
         q_item.rx_byte != 8'd0) |=> collecting_reg)
        else $error("legal length byte did not open a frame");

endmodule

FILE: rtl/core/camera_link_frame_receiver_unit.sv
// Top level of the serial frame receiver: configuration registers, the
// classifying front with its queue, and the deframing back end.
// A request accepted into the queue is deframed when popped; any result it gives is held in the output register.
// Throughput: one request per cycle while item_stall is low; the queue and
// the output register let the input keep flowing while a result waits to be taken.
// Reset: asynchronous, active low; hunting state, timers cleared, registers at defaults.
`timescale 1ns / 1ps

module camera_link_frame_receiver_unit #(
    parameter int QUEUE_DEPTH = clfr_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  clfr_pkg::clfr_in_t   item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output clfr_pkg::clfr_out_t  result
);

    clfr_pkg::clfr_cfg_t  cfg_reg;
    logic                 q_valid;
    logic                 q_pop;
    clfr_pkg::clfr_item_t q_item;

    // Hold configuration; writes land by index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_length       <= clfr_pkg::RST_MIN_LENGTH;
            cfg_reg.max_length       <= clfr_pkg::RST_MAX_LENGTH;
            cfg_reg.frame_timeout_ms <= clfr_pkg::RST_FRAME_TO;
            cfg_reg.byte_timeout_ms  <= clfr_pkg::RST_BYTE_TO;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                clfr_pkg::CFG_MIN_LENGTH: cfg_reg.min_length       <= cfg_data[7:0];
                clfr_pkg::CFG_MAX_LENGTH: cfg_reg.max_length       <= cfg_data[7:0];
                clfr_pkg::CFG_FRAME_TO:   cfg_reg.frame_timeout_ms <= cfg_data;
                clfr_pkg::CFG_BYTE_TO:    cfg_reg.byte_timeout_ms  <= cfg_data;
                default:                  cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    clfr_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .min_length (cfg_reg.min_length),
        .max_length (cfg_reg.max_length),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    clfr_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .frame_timeout_ms (cfg_reg.frame_timeout_ms),
        .byte_timeout_ms  (cfg_reg.byte_timeout_ms),
        .q_valid          (q_valid),
        .q_item           (q_item),
        .q_pop            (q_pop),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .result           (result)
    );

endmodule
